FILE: hw/rtl/dpl_pkg.sv
// Shared types, constants and the control word layout for the pendulum LED ring driver.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package dpl_pkg;

	// Ring and frame geometry.
	localparam int LED_TOTAL        = 40;
	localparam int FRAME_WORDS      = LED_TOTAL + 2;
	localparam int FRAME_LAST       = FRAME_WORDS - 1;
	localparam int IDX_W            = 6;
	// Sine lookup resolution: power of two, the angle keeps the top TBL_BITS of the phase.
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int TBL_BITS         = $clog2(SINE_TABLE_DEPTH);

	// Datapath widths.
	localparam int PHASE_W = 32;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 48;
	localparam int PROJ_W  = 18;
	localparam int TRIG_W  = 17;
	localparam int QUO_W   = 16;
	localparam int DEN_W   = 35;
	localparam int REM_W   = 36;
	localparam int CNT_W   = 5;
	localparam int UPC_W   = 5;

	// Configuration registers.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIT_WORD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DARK     = 2'd3;

	localparam logic [15:0] DAMPING_RST   = 16'd6554;
	localparam logic [23:0] GAIN_RST      = 24'd106808;
	localparam logic [31:0] LIT_WORD_RST  = 32'hFFFF_FFE1;
	localparam logic [31:0] DARK_WORD_RST = 32'h0000_00E0;
	localparam logic [31:0] START_WORD    = 32'h0000_0000;
	localparam logic [31:0] END_WORD      = 32'hFFFF_FFFF;

	// Multiplier operand selection.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQ,
		MUL_AYC,
		MUL_AXS,
		MUL_AG,
		MUL_VD,
		MUL_LED
	} mul_sel_t;

	// Register-transfer operation of one step.
	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_DIV_INIT,
		ALU_DIV_STEP,
		ALU_SIN_WR,
		ALU_COS_WR,
		ALU_ACC_LD,
		ALU_ACC_SUB,
		ALU_A_LD,
		ALU_V_ADD,
		ALU_V_DAMP,
		ALU_V_SAT,
		ALU_LED_LD,
		ALU_EMIT
	} alu_op_t;

	// Step counter sequencing.
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_DIV,
		JMP_EMIT
	} jmp_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		alu_op_t  alu_op;
		jmp_t     jump;
	} ctrl_t;

	localparam ctrl_t CTRL_IDLE = '{mul_sel: MUL_NONE, alu_op: ALU_NOP, jump: JMP_NEXT};

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic div_last;
		logic emit_done;
	} stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dpl_ucode_rom.sv
// Read-only microprogram: one control word per step of the tick computation.
// Depends on dpl_pkg for the control word layout.
`default_nettype none
module dpl_ucode_rom (
	input  logic [dpl_pkg::UPC_W-1:0] upc,
	output dpl_pkg::ctrl_t            word
);

	// Sine, then cosine (Bhaskara quotient), projection, Euler step, LED pick, frame.
	always_comb begin
		word = dpl_pkg::CTRL_IDLE;
		case (upc)
			5'd0:  word = '{dpl_pkg::MUL_SQ,   dpl_pkg::ALU_NOP,      dpl_pkg::JMP_NEXT};
			5'd1:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_DIV_INIT, dpl_pkg::JMP_NEXT};
			5'd2:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_DIV_STEP, dpl_pkg::JMP_DIV};
			5'd3:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_SIN_WR,   dpl_pkg::JMP_NEXT};
			5'd4:  word = '{dpl_pkg::MUL_SQ,   dpl_pkg::ALU_NOP,      dpl_pkg::JMP_NEXT};
			5'd5:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_DIV_INIT, dpl_pkg::JMP_NEXT};
			5'd6:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_DIV_STEP, dpl_pkg::JMP_DIV};
			5'd7:  word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_COS_WR,   dpl_pkg::JMP_NEXT};
			5'd8:  word = '{dpl_pkg::MUL_AYC,  dpl_pkg::ALU_NOP,      dpl_pkg::JMP_NEXT};
			5'd9:  word = '{dpl_pkg::MUL_AXS,  dpl_pkg::ALU_ACC_LD,   dpl_pkg::JMP_NEXT};
			5'd10: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_ACC_SUB,  dpl_pkg::JMP_NEXT};
			5'd11: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_A_LD,     dpl_pkg::JMP_NEXT};
			5'd12: word = '{dpl_pkg::MUL_AG,   dpl_pkg::ALU_NOP,      dpl_pkg::JMP_NEXT};
			5'd13: word = '{dpl_pkg::MUL_VD,   dpl_pkg::ALU_V_ADD,    dpl_pkg::JMP_NEXT};
			5'd14: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_V_DAMP,   dpl_pkg::JMP_NEXT};
			5'd15: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_V_SAT,    dpl_pkg::JMP_NEXT};
			5'd16: word = '{dpl_pkg::MUL_LED,  dpl_pkg::ALU_NOP,      dpl_pkg::JMP_NEXT};
			5'd17: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_LED_LD,   dpl_pkg::JMP_NEXT};
			5'd18: word = '{dpl_pkg::MUL_NONE, dpl_pkg::ALU_EMIT,     dpl_pkg::JMP_EMIT};
			default: word = dpl_pkg::CTRL_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/dpl_sequencer.sv
// Step counter and jump logic that walks the microprogram once per accepted tick.
// Depends on dpl_pkg and dpl_ucode_rom.
`default_nettype none
module dpl_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dpl_pkg::stat_t stat,
	output logic           busy,
	output dpl_pkg::ctrl_t ctrl
);

	logic [dpl_pkg::UPC_W-1:0] upc_q;
	logic                      busy_q;
	dpl_pkg::ctrl_t            rom_word;

	dpl_ucode_rom u_rom (
		.upc  (upc_q),
		.word (rom_word)
	);

	// Step counter: advance, hold on a loop step, or finish after the last frame word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			upc_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			case (rom_word.jump)
				dpl_pkg::JMP_NEXT: upc_q <= upc_q + 1'b1;
				dpl_pkg::JMP_DIV: begin
					if (stat.div_last) upc_q <= upc_q + 1'b1;
				end
				dpl_pkg::JMP_EMIT: begin
					if (stat.emit_done) busy_q <= 1'b0;
				end
				default: upc_q <= upc_q;
			endcase
		end
	end

	assign busy = busy_q;
	assign ctrl = busy_q ? rom_word : dpl_pkg::CTRL_IDLE;

endmodule
`default_nettype wire

FILE: hw/rtl/dpl_datapath.sv
// Arithmetic datapath: shared multiplier, restoring divider for the sine form,
// projection accumulator and the phase/velocity state. Depends on dpl_pkg.
`default_nettype none
module dpl_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [15:0]          accel_x,
	input  logic signed [15:0]          accel_y,
	input  dpl_pkg::ctrl_t              ctrl,
	input  logic [15:0]                 damping_coeff,
	input  logic [23:0]                 accel_gain,
	output logic                        div_last,
	output logic [dpl_pkg::IDX_W-1:0]   led
);

	localparam logic signed [dpl_pkg::ACC_W-1:0] VEL_MAX = 48'sd2147483647;
	localparam logic signed [dpl_pkg::ACC_W-1:0] VEL_MIN = -48'sd2147483648;
	localparam logic [dpl_pkg::PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [dpl_pkg::CNT_W-1:0]   DIV_STEPS    = 5'(dpl_pkg::QUO_W);

	logic signed [15:0]                   ax_q, ay_q;
	logic [dpl_pkg::PHASE_W-1:0]          ang_q;
	logic [dpl_pkg::PHASE_W-1:0]          phase_q;
	logic signed [dpl_pkg::PHASE_W-1:0]   vel_q;
	logic signed [dpl_pkg::TRIG_W-1:0]    sin_q, cos_q;
	logic signed [dpl_pkg::PROD_W-1:0]    prod_q;
	logic signed [dpl_pkg::ACC_W-1:0]     acc_q;
	logic signed [dpl_pkg::PROJ_W-1:0]    proj_q;
	logic [dpl_pkg::DEN_W-1:0]            den_q;
	logic [dpl_pkg::REM_W-1:0]            rem_q;
	logic [dpl_pkg::QUO_W-1:0]            quo_q;
	logic [dpl_pkg::CNT_W-1:0]            cnt_q;
	logic [dpl_pkg::IDX_W-1:0]            led_q;

	logic signed [dpl_pkg::MUL_A_W-1:0]   mul_a;
	logic signed [dpl_pkg::MUL_B_W-1:0]   mul_b;
	logic [15:0]                          h;
	logic [dpl_pkg::REM_W-1:0]            rem_sh;
	logic                                 rem_ge;
	logic signed [dpl_pkg::TRIG_W-1:0]    trig_pos, trig_val;
	logic signed [dpl_pkg::ACC_W-1:0]     vel_ext, damp_ext;
	logic signed [dpl_pkg::PHASE_W-1:0]   vel_sat;

	// Half-turn position used by the Bhaskara form.
	assign h = ang_q[30:15];

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			dpl_pkg::MUL_SQ: begin
				mul_a = $signed({17'd0, h});
				mul_b = $signed({8'd0, 17'h1_0000 - {1'b0, h}});
			end
			dpl_pkg::MUL_AYC: begin
				mul_a = 33'(ay_q);
				mul_b = 25'(cos_q);
			end
			dpl_pkg::MUL_AXS: begin
				mul_a = 33'(ax_q);
				mul_b = 25'(sin_q);
			end
			dpl_pkg::MUL_AG: begin
				mul_a = 33'(proj_q);
				mul_b = $signed({1'b0, accel_gain});
			end
			dpl_pkg::MUL_VD: begin
				mul_a = 33'(vel_q);
				mul_b = $signed({9'd0, damping_coeff});
			end
			dpl_pkg::MUL_LED: begin
				mul_a = $signed({1'b0, phase_q});
				mul_b = 25'(dpl_pkg::LED_TOTAL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider step: shift in a zero numerator bit and subtract when it fits.
	assign rem_sh = {rem_q[dpl_pkg::REM_W-2:0], 1'b0};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	// Quotient is the sine magnitude; the upper half turn negates it.
	assign trig_pos = $signed({1'b0, quo_q});
	assign trig_val = ang_q[31] ? -trig_pos : trig_pos;

	// Velocity terms and saturation to the signed 32-bit range.
	assign vel_ext  = 48'(vel_q);
	assign damp_ext = 48'($signed(prod_q[47:16]));
	always_comb begin
		if (acc_q > VEL_MAX) begin
			vel_sat = VEL_MAX[31:0];
		end else if (acc_q < VEL_MIN) begin
			vel_sat = VEL_MIN[31:0];
		end else begin
			vel_sat = acc_q[31:0];
		end
	end

	// Pendulum state and divider control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			vel_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (ctrl.alu_op)
				dpl_pkg::ALU_DIV_INIT: cnt_q <= DIV_STEPS;
				dpl_pkg::ALU_DIV_STEP: cnt_q <= cnt_q - 1'b1;
				dpl_pkg::ALU_V_SAT: begin
					vel_q   <= vel_sat;
					phase_q <= phase_q + vel_sat;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Working registers driven by the control word.
	always_ff @(posedge clk) begin
		if (start) begin
			ax_q  <= accel_x;
			ay_q  <= accel_y;
			ang_q <= {phase_q[31 -: dpl_pkg::TBL_BITS],
			          {(dpl_pkg::PHASE_W - dpl_pkg::TBL_BITS){1'b0}}};
		end
		if (ctrl.mul_sel != dpl_pkg::MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		case (ctrl.alu_op)
			dpl_pkg::ALU_DIV_INIT: begin
				den_q <= (35'd5 << 32) - {prod_q[32:0], 2'b00};
				rem_q <= {prod_q[32:0], 3'b000};
				quo_q <= '0;
			end
			dpl_pkg::ALU_DIV_STEP: begin
				rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[dpl_pkg::QUO_W-2:0], rem_ge};
			end
			dpl_pkg::ALU_SIN_WR: begin
				sin_q <= trig_val;
				ang_q <= ang_q + QUARTER_TURN;
			end
			dpl_pkg::ALU_COS_WR: cos_q  <= trig_val;
			dpl_pkg::ALU_ACC_LD: acc_q  <= prod_q[47:0];
			dpl_pkg::ALU_ACC_SUB: acc_q <= acc_q - prod_q[47:0];
			dpl_pkg::ALU_A_LD: proj_q   <= acc_q[32:15];
			dpl_pkg::ALU_V_ADD: acc_q   <= vel_ext + prod_q[47:0];
			dpl_pkg::ALU_V_DAMP: acc_q  <= acc_q - damp_ext;
			dpl_pkg::ALU_LED_LD: led_q  <= prod_q[32 +: dpl_pkg::IDX_W];
			default: acc_q <= acc_q;
		endcase
	end

	assign div_last = cnt_q == 5'd1;
	assign led      = led_q;

endmodule
`default_nettype wire

FILE: hw/rtl/dpl_frame_out.sv
// Frame word generator with the output register of the result channel.
// Depends on dpl_pkg.
`default_nettype none
module dpl_frame_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpl_pkg::ctrl_t            ctrl,
	input  logic [dpl_pkg::IDX_W-1:0] led,
	input  logic [31:0]               lit_word,
	input  logic [31:0]               dark_word,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [31:0]               frame_word,
	output logic [dpl_pkg::IDX_W-1:0] word_index,
	output logic [dpl_pkg::IDX_W-1:0] lit_led,
	output logic                      last_word,
	output logic                      emit_done
);

	localparam logic [dpl_pkg::IDX_W-1:0] LAST_IDX = 6'(dpl_pkg::FRAME_LAST);

	logic [dpl_pkg::IDX_W-1:0] cnt_q;
	logic                      valid_q;
	logic [31:0]               word_q;
	logic [dpl_pkg::IDX_W-1:0] index_q, led_out_q;
	logic                      last_q;
	logic                      load;
	logic                      at_last;
	logic [31:0]               next_word;

	assign load    = (ctrl.alu_op == dpl_pkg::ALU_EMIT) && (!valid_q || out_ready);
	assign at_last = cnt_q == LAST_IDX;

	// Word for the current position: start, end, lit LED or dark LED.
	always_comb begin
		if (cnt_q == '0) begin
			next_word = dpl_pkg::START_WORD;
		end else if (at_last) begin
			next_word = dpl_pkg::END_WORD;
		end else if (cnt_q == led + 1'b1) begin
			next_word = lit_word;
		end else begin
			next_word = dark_word;
		end
	end

	// Output register: refilled when empty or when its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= at_last ? '0 : cnt_q + 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q    <= next_word;
			index_q   <= cnt_q;
			led_out_q <= led;
			last_q    <= at_last;
		end
	end

	assign emit_done  = load && at_last;
	assign out_valid  = valid_q;
	assign frame_word = word_q;
	assign word_index = index_q;
	assign lit_led    = led_out_q;
	assign last_word  = last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/damped_pendulum_led_ring_driver_unit.sv
// Top level of the damped pendulum LED ring driver: configuration registers and wiring.
// Depends on dpl_pkg, dpl_sequencer, dpl_datapath and dpl_frame_out.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     accel_x, accel_y
//   out      output     out_valid/out_ready   frame_word, word_index, lit_led, last_word
//   cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// After acceptance, each tick runs two sine evaluations, each bounded by the 16-step divider,
// then projection, Euler update and LED choice, followed by 42 frame words at one per cycle
// while the output is not stalled. No new tick is taken until the last frame word is loaded.
// Output stalls hold the frame sequencer; the last word may wait while the next tick is taken.
// Reset clears phase, velocity and control and restores the register defaults.
`default_nettype none
module damped_pendulum_led_ring_driver_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                accel_x,
	input  logic signed [15:0]                accel_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       frame_word,
	output logic [5:0]                        word_index,
	output logic [5:0]                        lit_led,
	output logic                              last_word,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [15:0]    damping_q;
	logic [23:0]    gain_q;
	logic [31:0]    lit_word_q;
	logic [31:0]    dark_word_q;
	logic           busy;
	logic           start;
	dpl_pkg::ctrl_t ctrl;
	dpl_pkg::stat_t stat;
	logic           div_last;
	logic           emit_done;
	logic [5:0]     led;

	assign in_ready  = !busy;
	assign start     = in_valid && !busy;
	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q   <= dpl_pkg::DAMPING_RST;
			gain_q      <= dpl_pkg::GAIN_RST;
			lit_word_q  <= dpl_pkg::LIT_WORD_RST;
			dark_word_q <= dpl_pkg::DARK_WORD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpl_pkg::CFG_DAMPING:  damping_q   <= cfg_data[15:0];
				dpl_pkg::CFG_GAIN:     gain_q      <= cfg_data[23:0];
				dpl_pkg::CFG_LIT_WORD: lit_word_q  <= cfg_data;
				dpl_pkg::CFG_DARK:     dark_word_q <= cfg_data;
				default:               damping_q   <= damping_q;
			endcase
		end
	end

	assign stat = '{div_last: div_last, emit_done: emit_done};

	dpl_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	dpl_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.ctrl          (ctrl),
		.damping_coeff (damping_q),
		.accel_gain    (gain_q),
		.div_last      (div_last),
		.led           (led)
	);

	dpl_frame_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.led        (led),
		.lit_word   (lit_word_q),
		.dark_word  (dark_word_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.frame_word (frame_word),
		.word_index (word_index),
		.lit_led    (lit_led),
		.last_word  (last_word),
		.emit_done  (emit_done)
	);

endmodule
`default_nettype wire

FILE: tb/damped_pendulum_led_ring_driver_unit_tb.sv
// Self-checking testbench for the damped pendulum LED ring driver: a scoreboard class predicts
// each 42-word strip frame from the accelerometer ticks and checks it word by word.
// Depends on dpl_pkg and the damped_pendulum_led_ring_driver_unit RTL.
`default_nettype none
module damped_pendulum_led_ring_driver_unit_tb;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 12;
	localparam int TAIL_CYCLES    = 120;
	localparam int TIMEOUT_CYCLES = 5_000_000;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_TICKS    = 96;

	localparam logic signed [15:0] ACC_MAX = 16'sh7FFF;
	localparam logic signed [15:0] ACC_MIN = 16'sh8000;

	// One word of a strip frame as it leaves the block.
	typedef struct {
		logic [31:0] word;
		logic [5:0]  index;
		logic [5:0]  led;
		logic        last;
	} frame_beat_t;

	// Tracks the pendulum state and the registers, and holds the frame words still to come.
	class frame_scoreboard;
		logic [15:0]        damping;
		logic [23:0]        gain;
		logic [31:0]        lit_pattern;
		logic [31:0]        dark_pattern;
		logic [31:0]        phase;
		logic signed [31:0] velocity;
		frame_beat_t        frame_words_due[$];
		bit                 led_hit[dpl_pkg::LED_TOTAL];
		int                 errors;
		int                 ticks_noted;
		int                 words_checked;
		int                 clamp_count;

		function new();
			damping      = dpl_pkg::DAMPING_RST;
			gain         = dpl_pkg::GAIN_RST;
			lit_pattern  = dpl_pkg::LIT_WORD_RST;
			dark_pattern = dpl_pkg::DARK_WORD_RST;
			phase        = '0;
			velocity     = '0;
			errors       = 0;
			ticks_noted  = 0;
			words_checked = 0;
			clamp_count  = 0;
		endfunction

		// Register write; bits above each register's width are dropped.
		function void write_reg(logic [dpl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				dpl_pkg::CFG_DAMPING:  damping      = data[15:0];
				dpl_pkg::CFG_GAIN:     gain         = data[23:0];
				dpl_pkg::CFG_LIT_WORD: lit_pattern  = data;
				dpl_pkg::CFG_DARK:     dark_pattern = data;
				default: ;
			endcase
		endfunction

		// Bhaskara sine in Q1.15 over a 2^32 turn; the upper half turn is negated.
		function longint bhaskara_sine(logic [31:0] ang);
			longint unsigned h;
			longint unsigned u;
			longint unsigned quo;
			h   = {48'b0, ang[30:15]};
			u   = h * (64'd65536 - h);
			quo = (u << 19) / ((64'd5 << 32) - 64'd4 * u);
			return ang[31] ? -longint'(quo) : longint'(quo);
		endfunction

		// Angle of the table entry that covers the phase.
		function logic [31:0] table_angle(logic [31:0] ph);
			longint unsigned depth;
			longint unsigned k;
			longint unsigned ang;
			depth = dpl_pkg::SINE_TABLE_DEPTH;
			k     = ({32'b0, ph} * depth) >> 32;
			ang   = (k << 32) / depth;
			return ang[31:0];
		endfunction

		// One Euler step for an accepted tick, then queue the frame that it produces.
		function void note_tick(logic signed [15:0] ax, logic signed [15:0] ay);
			logic [31:0]     ang;
			longint          sn;
			longint          cs;
			longint          tangential;
			longint          vel;
			longint          next_vel;
			longint unsigned led_prod;
			logic [5:0]      led;
			frame_beat_t     beat;
			ang        = table_angle(phase);
			sn         = bhaskara_sine(ang);
			cs         = bhaskara_sine(ang + 32'h4000_0000);
			tangential = (longint'(ay) * cs - longint'(ax) * sn) >>> 15;
			vel        = longint'(velocity);
			next_vel   = vel + tangential * longint'({40'b0, gain})
			             - ((vel * longint'({48'b0, damping})) >>> 16);
			// Clamp to the signed 32-bit range.
			if (next_vel > 64'sd2147483647) begin
				next_vel = 64'sd2147483647;
				clamp_count++;
			end else if (next_vel < -64'sd2147483648) begin
				next_vel = -64'sd2147483648;
				clamp_count++;
			end
			velocity = next_vel[31:0];
			phase    = phase + next_vel[31:0];
			led_prod = {32'b0, phase} * 64'(dpl_pkg::LED_TOTAL);
			led      = led_prod[37:32];
			led_hit[led] = 1'b1;
			ticks_noted++;
			// Start word, one word per LED, end word.
			for (int i = 0; i < dpl_pkg::FRAME_WORDS; i++) begin
				if (i == 0)
					beat.word = dpl_pkg::START_WORD;
				else if (i == dpl_pkg::FRAME_LAST)
					beat.word = dpl_pkg::END_WORD;
				else if (i == int'(led) + 1)
					beat.word = lit_pattern;
				else
					beat.word = dark_pattern;
				beat.index = 6'(i);
				beat.led   = led;
				beat.last  = (i == dpl_pkg::FRAME_LAST);
				frame_words_due.push_back(beat);
			end
		endfunction

		// Compare one accepted frame word with the oldest one due.
		function void check_word(frame_beat_t got);
			frame_beat_t due;
			if (frame_words_due.size() == 0) begin
				$display("%0t: unexpected frame word %h index %0d", $time, got.word, got.index);
				errors++;
				return;
			end
			due = frame_words_due.pop_front();
			words_checked++;
			if (got.word !== due.word) begin
				$display("%0t: frame_word expected %h actual %h (index %0d)",
				         $time, due.word, got.word, due.index);
				errors++;
			end
			if (got.index !== due.index) begin
				$display("%0t: word_index expected %0d actual %0d", $time, due.index, got.index);
				errors++;
			end
			if (got.led !== due.led) begin
				$display("%0t: lit_led expected %0d actual %0d", $time, due.led, got.led);
				errors++;
			end
			if (got.last !== due.last) begin
				$display("%0t: last_word expected %b actual %b (index %0d)",
				         $time, due.last, got.last, due.index);
				errors++;
			end
		endfunction

		function int leds_covered();
			int n;
			n = 0;
			foreach (led_hit[i])
				if (led_hit[i])
					n++;
			return n;
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic signed [15:0]              accel_x = '0;
	logic signed [15:0]              accel_y = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [31:0]                     frame_word;
	logic [5:0]                      word_index;
	logic [5:0]                      lit_led;
	logic                            last_word;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dpl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [31:0]                     cfg_data = '0;

	frame_scoreboard sb = new();
	bit              sender_steady = 1'b0;
	bit              sink_steady = 1'b0;
	int              settings_loaded = 0;

	damped_pendulum_led_ring_driver_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_word (frame_word),
		.word_index (word_index),
		.lit_led    (lit_led),
		.last_word  (last_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock generation.
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("timeout with %0d frame words outstanding", sb.frame_words_due.size());
		$display("damped_pendulum_led_ring_driver_unit test failed");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Accelerometer sample: mostly full range, some small values, some extremes.
	function automatic logic signed [15:0] random_accel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return ACC_MAX;
				1: return ACC_MIN;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end else if (r < 4) begin
			return 16'($signed($urandom_range(0, 1024)) - 512);
		end
		return 16'($urandom);
	endfunction

	// Frame sink: checks every accepted word and stalls at random.
	initial begin
		frame_beat_t got;
		int          stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.word  = frame_word;
				got.index = word_index;
				got.led   = lit_led;
				got.last  = last_word;
				sb.check_word(got);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!sink_steady && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				stall_left = gap_len();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Send one tick and wait for its transaction; valid stays high afterwards.
	task automatic drive_tick(input logic signed [15:0] ax, input logic signed [15:0] ay);
		int gap;
		gap = sender_steady ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x  <= ax;
		accel_y  <= ay;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(ax, ay);
	endtask

	// Stop sending and wait until every frame word due has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.frame_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; junk above each width must be ignored.
	task automatic load_settings(input logic [15:0] damp, input logic [23:0] gain,
	                             input logic [31:0] lit, input logic [31:0] dark);
		logic [dpl_pkg::CFG_IDX_W-1:0] order [4];
		logic [31:0]                   value [4];
		order = '{dpl_pkg::CFG_DAMPING, dpl_pkg::CFG_GAIN, dpl_pkg::CFG_LIT_WORD,
		          dpl_pkg::CFG_DARK};
		value = '{{16'($urandom), damp}, {8'($urandom), gain}, lit, dark};
		for (int r = 0; r < 4; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[r];
			cfg_data  <= value[r];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(order[r], value[r]);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// Stimulus: directed ticks under a few settings, then random phases.
	initial begin
		logic signed [15:0] dir_x [$];
		logic signed [15:0] dir_y [$];
		logic [15:0]        damp;
		logic [23:0]        gain;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a negative step from phase zero, then the sample extremes.
		dir_x = '{16'sd0, 16'sd0, ACC_MAX, ACC_MIN, ACC_MAX, ACC_MIN, 16'sd0, 16'sd0,
		          ACC_MAX, ACC_MIN, 16'sh5555, -16'sh5556};
		dir_y = '{-16'sd1, 16'sd0, ACC_MAX, ACC_MIN, ACC_MIN, ACC_MAX, ACC_MAX, ACC_MIN,
		          16'sd0, 16'sd0, -16'sh5556, 16'sh5555};
		foreach (dir_x[i])
			drive_tick(dir_x[i], dir_y[i]);
		drain();

		// Full gain, no damping: drive the velocity into both clamps.
		load_settings(16'd0, 24'hFF_FFFF, 32'h1234_5678, 32'h8765_4321);
		dir_x = '{16'sd0, 16'sd0, 16'sd0, ACC_MIN, 16'sd0, 16'sd0, 16'sd0};
		dir_y = '{ACC_MAX, ACC_MAX, ACC_MAX, ACC_MIN, ACC_MIN, ACC_MIN, ACC_MIN};
		foreach (dir_x[i])
			drive_tick(dir_x[i], dir_y[i]);
		drain();

		// Full damping, zero gain, inverted frame words: the velocity dies away.
		load_settings(16'hFFFF, 24'd0, 32'h0000_0000, 32'hFFFF_FFFF);
		drive_tick(ACC_MAX, ACC_MAX);
		drive_tick(ACC_MIN, ACC_MIN);
		drive_tick(16'sd1, -16'sd1);
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: load_settings(dpl_pkg::DAMPING_RST, dpl_pkg::GAIN_RST,
				                 dpl_pkg::LIT_WORD_RST, dpl_pkg::DARK_WORD_RST);
				1: load_settings(16'd0, 24'd1, $urandom, $urandom);
				2: load_settings(16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
				3: load_settings(16'($urandom), 24'($urandom), $urandom, $urandom);
				default: begin
					damp = 16'($urandom_range(0, 20000));
					gain = 24'($urandom_range(0, 300000));
					load_settings(damp, gain, $urandom, $urandom);
				end
			endcase
			sender_steady = (ph == 3);
			sink_steady   = (ph == 3) || (ph == 1 && $urandom_range(0, 1) == 1);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// In phase 1 only, once midway, hold off until the pipeline is empty.
				if (ph == 1 && n == PHASE_TICKS / 2)
					drain();
				drive_tick(random_accel(), random_accel());
			end
			drain();
		end

		// Let any stray output show up, then report.
		sink_steady = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.frame_words_due.size() != 0)
			$display("%0d frame words never arrived", sb.frame_words_due.size());
		$display("Ran %0d ticks and checked %0d frame words under %0d register settings.",
		         sb.ticks_noted, sb.words_checked, settings_loaded + 1);
		$display("%0d of %0d LEDs were lit; the velocity clamped %0d times.",
		         sb.leds_covered(), dpl_pkg::LED_TOTAL, sb.clamp_count);
		if (sb.errors == 0 && sb.frame_words_due.size() == 0)
			$display("damped_pendulum_led_ring_driver_unit test passed");
		else
			$display("damped_pendulum_led_ring_driver_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
